[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRRW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srrw: same-cycle check failed");

// Next-cycle implication.
`define SRRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srrw: next-cycle check failed");

`endif

[rtl/core/srrw_pkg.sv]
// ---------------------------------------------------------------------------
// srrw_pkg
// Types and fixed field widths of the selective repeat receive window.
// ---------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

  localparam int WIN_W       = 6;
  localparam int SEQ_W       = 8;
  localparam int REF_W       = 32;
  localparam int LEN_W       = 10;
  localparam int STATUS_W    = 3;
  localparam int SLOT_DATA_W = REF_W + LEN_W;
  localparam int CFG_IDX_W   = 1;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_DUP     = 3'd1,
    ST_OLD     = 3'd2,
    ST_BAD     = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  // Frame classification handed from the resolver to the controller.
  typedef struct packed {
    logic ignore;  // outside the acceptable index range
    logic old;     // below the delivery point
  } res_cls_t;

endpackage

`default_nettype wire

[rtl/core/selective_repeat_receive_window.sv]
// ---------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of a selective repeat ARQ link: classifies frames, buffers
// out-of-order ones and delivers the in-order run.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Carries
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       in_valid_i / in_stall_o   frame_ok, seq_num, payload_ref/len
//  out      source     out_valid_o / out_stall_i status, ack, delivery, all, last
//  cfg      sink       cfg_valid_i / cfg_ready_o register index and write data
//
//  One item at a time. A corrupted frame goes straight to its result.
//  Otherwise the index is resolved (S_RES_A, S_RES_B, S_CLASSIFY); an
//  ignored or already delivered frame then gives its result, and any
//  other runs the slot scan (one filled bit per cycle) and then reads
//  each delivered frame from the slot memory into the output register.
//  Reset clears the delivery point, the filled bits and the FSM; slot
//  contents are only read once filled and need no clearing.
//  A stalled result sits in the output register; the block holds its
//  delivery loop until that register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module selective_repeat_receive_window #(
  parameter int MAX_WINDOW = 32,
  parameter int INDEX_BITS = 24
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // config
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [srrw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [INDEX_BITS-1:0]            cfg_wdata_i,
  // received frames
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic                             frame_ok_i,
  input  wire logic [srrw_pkg::SEQ_W-1:0]       seq_num_i,
  input  wire logic [srrw_pkg::REF_W-1:0]       payload_ref_i,
  input  wire logic [srrw_pkg::LEN_W-1:0]       payload_len_i,
  // results
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [srrw_pkg::STATUS_W-1:0]    status_o,
  output      logic                             ack_valid_o,
  output      logic [srrw_pkg::SEQ_W-1:0]       ack_seq_o,
  output      logic                             deliver_valid_o,
  output      logic [INDEX_BITS-1:0]            deliver_index_o,
  output      logic [srrw_pkg::REF_W-1:0]       deliver_ref_o,
  output      logic [srrw_pkg::LEN_W-1:0]       deliver_len_o,
  output      logic                             all_delivered_o,
  output      logic                             last_o
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RES_A,
    S_RES_B,
    S_CLASSIFY,
    S_SCAN,
    S_ONE,
    S_DEL_RD,
    S_DEL_LD
  } state_e;

  state_e state_q;

  // configuration
  logic [srrw_pkg::WIN_W-1:0] window_q;
  logic [INDEX_BITS-1:0]      total_q;

  // window state
  logic [INDEX_BITS-1:0] next_q;       // delivery point
  logic [SLOT_W-1:0]     next_slot_q;  // next_q mod MAX_WINDOW, tracked incrementally
  logic [MAX_WINDOW-1:0] filled_q;

  // current item
  logic [srrw_pkg::SEQ_W-1:0] in_seq_q;
  logic [srrw_pkg::REF_W-1:0] in_ref_q;
  logic [srrw_pkg::LEN_W-1:0] in_len_q;
  srrw_pkg::status_e          status_q;
  logic                       ack_q;
  logic [srrw_pkg::SEQ_W-1:0] ack_seq_q;
  logic                       all_q;

  // run scan / delivery counters
  logic [INDEX_BITS-1:0] scan_idx_q;
  logic [SLOT_W-1:0]     scan_ptr_q;
  logic [CNT_W-1:0]      scan_cnt_q;
  logic [CNT_W-1:0]      run_q;
  logic [CNT_W-1:0]      k_q;

  // output register
  logic                       out_valid_q;
  logic [srrw_pkg::STATUS_W-1:0] out_status_q;
  logic                       out_ack_q;
  logic [srrw_pkg::SEQ_W-1:0] out_ack_seq_q;
  logic                       out_dv_q;
  logic [INDEX_BITS-1:0]      out_di_q;
  logic [srrw_pkg::REF_W-1:0] out_dr_q;
  logic [srrw_pkg::LEN_W-1:0] out_dl_q;
  logic                       out_all_q;
  logic                       out_last_q;

  // resolver
  srrw_pkg::res_cls_t res_cls;
  logic [SLOT_W-1:0]  res_slot;

  // slot memory
  logic                             mem_we;
  logic                             mem_re;
  logic [srrw_pkg::SLOT_DATA_W-1:0] mem_rdata;

  logic              out_free;
  logic              scan_go;
  logic              del_last;
  logic [SLOT_W-1:0] next_slot_inc;
  logic [SLOT_W-1:0] scan_ptr_inc;

  assign out_free = !out_valid_q || !out_stall_i;

  // Run continues while under the cap, below total, and the slot is filled.
  assign scan_go = (scan_cnt_q < CNT_W'(MAX_WINDOW)) && (scan_idx_q < total_q) &&
                   filled_q[scan_ptr_q];

  assign del_last = (k_q + CNT_W'(1)) == run_q;

  assign next_slot_inc = (next_slot_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 :
                         next_slot_q + SLOT_W'(1);
  assign scan_ptr_inc  = (scan_ptr_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 :
                         scan_ptr_q + SLOT_W'(1);

  // A new frame lands in its slot during classification.
  assign mem_we = (state_q == S_CLASSIFY) && !res_cls.ignore && !res_cls.old &&
                  !filled_q[res_slot];
  assign mem_re = (state_q == S_DEL_RD) && out_free;

  srrw_resolve #(
    .MAX_WINDOW (MAX_WINDOW),
    .INDEX_BITS (INDEX_BITS),
    .SLOT_W     (SLOT_W)
  ) u_resolve (
    .clk_i       (clk_i),
    .window_i    (window_q),
    .total_i     (total_q),
    .next_i      (next_q),
    .next_slot_i (next_slot_q),
    .seq_i       (in_seq_q),
    .cls_o       (res_cls),
    .slot_o      (res_slot)
  );

  srrw_slot_mem #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (SLOT_W),
    .DATA_W (srrw_pkg::SLOT_DATA_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (res_slot),
    .wdata_i ({in_ref_q, in_len_q}),
    .re_i    (mem_re),
    .raddr_i (next_slot_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      window_q      <= srrw_pkg::WIN_W'(1);
      total_q       <= '0;
      next_q        <= '0;
      next_slot_q   <= '0;
      filled_q      <= '0;
      in_seq_q      <= '0;
      in_ref_q      <= '0;
      in_len_q      <= '0;
      status_q      <= srrw_pkg::ST_NEW;
      ack_q         <= 1'b0;
      ack_seq_q     <= '0;
      all_q         <= 1'b0;
      scan_idx_q    <= '0;
      scan_ptr_q    <= '0;
      scan_cnt_q    <= '0;
      run_q         <= '0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= '0;
      out_ack_q     <= 1'b0;
      out_ack_seq_q <= '0;
      out_dv_q      <= 1'b0;
      out_di_q      <= '0;
      out_dr_q      <= '0;
      out_dl_q      <= '0;
      out_all_q     <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      // config writes (the user must issue them only while idle; not enforced here)
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          srrw_pkg::REG_WINDOW_SIZE:  window_q <= cfg_wdata_i[srrw_pkg::WIN_W-1:0];
          srrw_pkg::REG_TOTAL_FRAMES: total_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // S_ONE reloads the register itself when it drains; S_DEL_LD finds it empty.
      if (out_valid_q && !out_stall_i && state_q != S_ONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_seq_q <= seq_num_i;
            in_ref_q <= payload_ref_i;
            in_len_q <= payload_len_i;
            if (!frame_ok_i) begin
              status_q  <= srrw_pkg::ST_BAD;
              ack_q     <= 1'b0;
              ack_seq_q <= '0;
              all_q     <= next_q >= total_q;
              state_q   <= S_ONE;
            end else begin
              state_q <= S_RES_A;
            end
          end
        end

        S_RES_A: state_q <= S_RES_B;

        S_RES_B: state_q <= S_CLASSIFY;

        S_CLASSIFY: begin
          if (res_cls.ignore) begin
            status_q  <= srrw_pkg::ST_IGNORED;
            ack_q     <= 1'b0;
            ack_seq_q <= '0;
            all_q     <= next_q >= total_q;
            state_q   <= S_ONE;
          end else if (res_cls.old) begin
            status_q  <= srrw_pkg::ST_OLD;
            ack_q     <= 1'b1;
            ack_seq_q <= in_seq_q;
            all_q     <= next_q >= total_q;
            state_q   <= S_ONE;
          end else begin
            if (filled_q[res_slot]) begin
              status_q <= srrw_pkg::ST_DUP;
            end else begin
              status_q           <= srrw_pkg::ST_NEW;
              filled_q[res_slot] <= 1'b1;
            end
            ack_q      <= 1'b1;
            ack_seq_q  <= in_seq_q;
            scan_idx_q <= next_q;
            scan_ptr_q <= next_slot_q;
            scan_cnt_q <= '0;
            state_q    <= S_SCAN;
          end
        end

        // Count the deliverable run first: all_delivered must be known
        // before the first result of the item goes out.
        S_SCAN: begin
          if (scan_go) begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
            scan_idx_q <= scan_idx_q + INDEX_BITS'(1);
            scan_ptr_q <= scan_ptr_inc;
          end else begin
            run_q   <= scan_cnt_q;
            all_q   <= scan_idx_q >= total_q;
            k_q     <= '0;
            state_q <= (scan_cnt_q == '0) ? S_ONE : S_DEL_RD;
          end
        end

        S_ONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= status_q;
            out_ack_q     <= ack_q;
            out_ack_seq_q <= ack_seq_q;
            out_dv_q      <= 1'b0;
            out_di_q      <= '0;
            out_dr_q      <= '0;
            out_dl_q      <= '0;
            out_all_q     <= all_q;
            out_last_q    <= 1'b1;
            state_q       <= S_IDLE;
          end
        end

        S_DEL_RD: begin
          if (out_free) begin
            state_q <= S_DEL_LD;
          end
        end

        // Output register is empty here: it was free when the read issued.
        S_DEL_LD: begin
          out_valid_q           <= 1'b1;
          out_status_q          <= status_q;
          out_ack_q             <= ack_q && (k_q == '0);
          out_ack_seq_q         <= ack_seq_q;
          out_dv_q              <= 1'b1;
          out_di_q              <= next_q;
          out_dr_q              <= mem_rdata[srrw_pkg::SLOT_DATA_W-1:srrw_pkg::LEN_W];
          out_dl_q              <= mem_rdata[srrw_pkg::LEN_W-1:0];
          out_all_q             <= all_q;
          out_last_q            <= del_last;
          filled_q[next_slot_q] <= 1'b0;
          next_q                <= next_q + INDEX_BITS'(1);
          next_slot_q           <= next_slot_inc;
          k_q                   <= k_q + CNT_W'(1);
          state_q               <= del_last ? S_IDLE : S_DEL_RD;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign ack_valid_o     = out_ack_q;
  assign ack_seq_o       = out_ack_seq_q;
  assign deliver_valid_o = out_dv_q;
  assign deliver_index_o = out_di_q;
  assign deliver_ref_o   = out_dr_q;
  assign deliver_len_o   = out_dl_q;
  assign all_delivered_o = out_all_q;
  assign last_o          = out_last_q;

  // Checks
  `SRRW_ASSERT_IMPL(a_load_into_free_out, (state_q == S_DEL_LD), !out_valid_q)
  `SRRW_ASSERT_IMPL(a_deliver_filled_slot, (state_q == S_DEL_LD), filled_q[next_slot_q])
  `SRRW_ASSERT_IMPL(a_scan_bounded, (state_q == S_SCAN),
                    scan_cnt_q <= CNT_W'(MAX_WINDOW))
  `SRRW_ASSERT_NEXT(a_delivery_advances, (state_q == S_DEL_LD),
                    next_q == $past(next_q) + INDEX_BITS'(1))

endmodule

`default_nettype wire

[rtl/core/srrw_slot_mem.sv]
// ---------------------------------------------------------------------------
// srrw_slot_mem
// Slot buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module srrw_slot_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 42
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/srrw_resolve.sv]
// ---------------------------------------------------------------------------
// srrw_resolve
// Two-stage sequence number resolver: window bounds, then index and slot.
// ---------------------------------------------------------------------------
`default_nettype none

module srrw_resolve #(
  parameter int MAX_WINDOW = 32,
  parameter int INDEX_BITS = 24,
  parameter int SLOT_W     = 5
) (
  input  wire logic                       clk_i,
  input  wire logic [srrw_pkg::WIN_W-1:0] window_i,
  input  wire logic [INDEX_BITS-1:0]      total_i,
  input  wire logic [INDEX_BITS-1:0]      next_i,
  input  wire logic [SLOT_W-1:0]          next_slot_i,
  input  wire logic [srrw_pkg::SEQ_W-1:0] seq_i,
  output      srrw_pkg::res_cls_t         cls_o,
  output      logic [SLOT_W-1:0]          slot_o
);

  // stage 1: lo = max(0, next-N), hi = min(total, next+N)
  logic [srrw_pkg::WIN_W-1:0] n_eff;
  logic [INDEX_BITS-1:0]      n_ext;
  logic [INDEX_BITS:0]        hi_sum;
  logic [INDEX_BITS-1:0]      lo_d, hi_d, lo_q, hi_q;

  always_comb begin
    if (window_i == '0) begin
      n_eff = srrw_pkg::WIN_W'(1);
    end else if (32'(window_i) > MAX_WINDOW) begin
      n_eff = srrw_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      n_eff = window_i;
    end
    n_ext  = INDEX_BITS'(n_eff);
    lo_d   = (next_i > n_ext) ? (next_i - n_ext) : '0;
    hi_sum = {1'b0, next_i} + {1'b0, n_ext};
    hi_d   = (hi_sum > {1'b0, total_i}) ? total_i : hi_sum[INDEX_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  // stage 2: idx = lo + ((seq - lo) mod 256), slot = (next_slot + idx - next) mod W
  logic [srrw_pkg::SEQ_W-1:0] off;
  logic [INDEX_BITS:0]        idx;
  logic [INDEX_BITS:0]        diff;
  logic [SLOT_W:0]            slot_sum;
  srrw_pkg::res_cls_t         cls_d;
  logic [SLOT_W-1:0]          slot_d;

  always_comb begin
    off          = seq_i - lo_q[srrw_pkg::SEQ_W-1:0];
    idx          = {1'b0, lo_q} + (INDEX_BITS+1)'(off);
    diff         = idx - {1'b0, next_i};
    cls_d.ignore = (lo_q >= hi_q) || (idx >= {1'b0, hi_q});
    cls_d.old    = idx < {1'b0, next_i};
    // idx - next < N <= MAX_WINDOW when the frame is buffered
    slot_sum     = {1'b0, next_slot_i} + {1'b0, diff[SLOT_W-1:0]};
    if (32'(slot_sum) >= MAX_WINDOW) begin
      slot_d = SLOT_W'(32'(slot_sum) - MAX_WINDOW);
    end else begin
      slot_d = slot_sum[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    cls_o  <= cls_d;
    slot_o <= slot_d;
  end

endmodule

`default_nettype wire

[sim/tb_selective_repeat_receive_window.sv]
// ---------------------------------------------------------------------------
// tb_selective_repeat_receive_window
// Self-checking bench for the selective repeat receive window: frames are
// classified and the in-order delivery runs are predicted per accepted item,
// then compared field by field against every result that leaves the block.
// ---------------------------------------------------------------------------

module tb_selective_repeat_receive_window;

  localparam int WIN_MAX     = 32;       // slot count of the receive buffer
  localparam int IDX_W       = 24;
  localparam int CYCLE_LIMIT = 500000;   // far above the slowest legal run
  localparam int ITEM_TARGET = 150;
  localparam int CLOSE_ITEMS = 20;       // items of the closing full-rate stretch
  localparam int HOLD_CYCLES = 300;      // long receiver hold-off

  // One result of the block, as seen on the output ports.
  typedef struct {
    logic [srrw_pkg::STATUS_W-1:0] status;
    logic                          ack_valid;
    logic [srrw_pkg::SEQ_W-1:0]    ack_seq;
    logic                          deliver_valid;
    logic [IDX_W-1:0]              deliver_index;
    logic [srrw_pkg::REF_W-1:0]    deliver_ref;
    logic [srrw_pkg::LEN_W-1:0]    deliver_len;
    logic                          all_delivered;
    logic                          last;
  } frame_result_t;

  // -------------------------------------------------------------------------
  // Window predictor plus the queue of results it still waits for.
  // -------------------------------------------------------------------------
  class window_scoreboard;
    logic [srrw_pkg::WIN_W-1:0] win_reg;
    logic [IDX_W-1:0]           total_reg;
    logic [IDX_W-1:0]           deliver_pt;
    bit                         held[WIN_MAX];
    logic [srrw_pkg::REF_W-1:0] held_ref[WIN_MAX];
    logic [srrw_pkg::LEN_W-1:0] held_len[WIN_MAX];
    frame_result_t              expected_q[$];
    int                         errors;

    function new();
      win_reg    = 1;
      total_reg  = '0;
      deliver_pt = '0;
      errors     = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void write_reg(logic [srrw_pkg::CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] data);
      if (idx == srrw_pkg::REG_WINDOW_SIZE) win_reg = data[srrw_pkg::WIN_W-1:0];
      else total_reg = data;
    endfunction

    // Effective window: 0 behaves as 1, anything above the slot count saturates.
    function int unsigned span();
      int unsigned n;
      n = win_reg;
      if (n < 1) n = 1;
      if (n > WIN_MAX) n = WIN_MAX;
      return n;
    endfunction

    function srrw_pkg::status_e note_frame(logic ok, logic [srrw_pkg::SEQ_W-1:0] seq,
                                           logic [srrw_pkg::REF_W-1:0] pref,
                                           logic [srrw_pkg::LEN_W-1:0] plen);
      int unsigned       n, lo, hi, idx, slot;
      srrw_pkg::status_e st;
      frame_result_t     run_q[$];
      frame_result_t     r;
      r = '{default: '0};
      if (!ok) begin
        st = srrw_pkg::ST_BAD;
      end else begin
        n  = span();
        lo = (deliver_pt > n) ? deliver_pt - n : 0;
        hi = deliver_pt + n;
        if (hi > total_reg) hi = total_reg;
        // unique index in [lo, hi) whose low byte matches seq
        idx = lo + ((32'(seq) - lo) & 32'hFF);
        if (lo >= hi || idx >= hi) begin
          st = srrw_pkg::ST_IGNORED;
        end else if (idx < deliver_pt) begin
          st = srrw_pkg::ST_OLD;
        end else begin
          slot = idx % WIN_MAX;
          if (held[slot]) begin
            st = srrw_pkg::ST_DUP;
          end else begin
            held[slot]     = 1'b1;
            held_ref[slot] = pref;
            held_len[slot] = plen;
            st             = srrw_pkg::ST_NEW;
          end
          // in-order run from the delivery point, capped at WIN_MAX items and at total_frames
          while (run_q.size() < WIN_MAX && deliver_pt < total_reg &&
                 held[deliver_pt % WIN_MAX]) begin
            slot            = deliver_pt % WIN_MAX;
            r.deliver_valid = 1'b1;
            r.deliver_index = deliver_pt;
            r.deliver_ref   = held_ref[slot];
            r.deliver_len   = held_len[slot];
            held[slot]      = 1'b0;
            run_q.push_back(r);
            deliver_pt++;
          end
        end
      end
      if (run_q.size() == 0) run_q.push_back(r);
      foreach (run_q[k]) begin
        run_q[k].status        = st;
        run_q[k].ack_valid     = (k == 0) && st != srrw_pkg::ST_BAD &&
                                 st != srrw_pkg::ST_IGNORED;
        run_q[k].ack_seq       = (st == srrw_pkg::ST_BAD || st == srrw_pkg::ST_IGNORED) ?
                                 '0 : seq;
        run_q[k].all_delivered = deliver_pt >= total_reg;
        run_q[k].last          = (k == run_q.size() - 1);
        expected_q.push_back(run_q[k]);
      end
      return st;
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0h index %0h",
                 $time, got.status, got.deliver_index);
        return;
      end
      want = expected_q.pop_front();
      cmp("status", 32'(want.status), 32'(got.status));
      cmp("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
      cmp("ack_seq", 32'(want.ack_seq), 32'(got.ack_seq));
      cmp("deliver_valid", 32'(want.deliver_valid), 32'(got.deliver_valid));
      cmp("deliver_index", 32'(want.deliver_index), 32'(got.deliver_index));
      cmp("deliver_ref", want.deliver_ref, got.deliver_ref);
      cmp("deliver_len", 32'(want.deliver_len), 32'(got.deliver_len));
      cmp("all_delivered", 32'(want.all_delivered), 32'(got.all_delivered));
      cmp("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, DUT
  // -------------------------------------------------------------------------
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [srrw_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [IDX_W-1:0]               cfg_wdata_i   = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic                           frame_ok_i    = 1'b0;
  logic [srrw_pkg::SEQ_W-1:0]     seq_num_i     = '0;
  logic [srrw_pkg::REF_W-1:0]     payload_ref_i = '0;
  logic [srrw_pkg::LEN_W-1:0]     payload_len_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [srrw_pkg::STATUS_W-1:0]  status_o;
  logic                           ack_valid_o;
  logic [srrw_pkg::SEQ_W-1:0]     ack_seq_o;
  logic                           deliver_valid_o;
  logic [IDX_W-1:0]               deliver_index_o;
  logic [srrw_pkg::REF_W-1:0]     deliver_ref_o;
  logic [srrw_pkg::LEN_W-1:0]     deliver_len_o;
  logic                           all_delivered_o;
  logic                           last_o;

  window_scoreboard sb = new();

  int          tx_pct      = 25;   // chance of a sender gap before an item
  int          rx_pct      = 20;   // chance of a receiver stall burst per cycle
  bit          hold_req    = 1'b0; // asks the receiver for one long hold-off
  int unsigned frames_sent = 0;    // items accepted so far
  int unsigned cycle_cnt   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  selective_repeat_receive_window #(
    .MAX_WINDOW (WIN_MAX),
    .INDEX_BITS (IDX_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frame_ok_i      (frame_ok_i),
    .seq_num_i       (seq_num_i),
    .payload_ref_i   (payload_ref_i),
    .payload_len_i   (payload_len_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .ack_valid_o     (ack_valid_o),
    .ack_seq_o       (ack_seq_o),
    .deliver_valid_o (deliver_valid_o),
    .deliver_index_o (deliver_index_o),
    .deliver_ref_o   (deliver_ref_o),
    .deliver_len_o   (deliver_len_o),
    .all_delivered_o (all_delivered_o),
    .last_o          (last_o)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor. Samples pre-edge values, so ordering within the step is moot.
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status        = status_o;
      got.ack_valid     = ack_valid_o;
      got.ack_seq       = ack_seq_o;
      got.deliver_valid = deliver_valid_o;
      got.deliver_index = deliver_index_o;
      got.deliver_ref   = deliver_ref_o;
      got.deliver_len   = deliver_len_o;
      got.all_delivered = all_delivered_o;
      got.last          = last_o;
      sb.check_result(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register fills and the block has to push back on its input.
  initial begin : rx_side
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks. Each is entered right after a rising edge; the send task
  // lowers valid only before a random gap, so back-to-back items keep it high.
  // -------------------------------------------------------------------------
  function automatic logic [srrw_pkg::LEN_W-1:0] rand_len();
    // mostly legal lengths, now and then an oversized one
    if ($urandom_range(0, 9) == 0) return srrw_pkg::LEN_W'($urandom_range(513, 1023));
    return srrw_pkg::LEN_W'($urandom_range(0, 512));
  endfunction

  task automatic send_frame(input logic ok, input logic [srrw_pkg::SEQ_W-1:0] seq,
                            input logic [srrw_pkg::REF_W-1:0] pref,
                            input logic [srrw_pkg::LEN_W-1:0] plen);
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_ok_i    <= ok;
    seq_num_i     <= seq;
    payload_ref_i <= pref;
    payload_len_i <= plen;
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.note_frame(ok, seq, pref, plen));
    frames_sent++;
  endtask

  task automatic send_index(input int unsigned idx);
    send_frame(1'b1, srrw_pkg::SEQ_W'(idx), $urandom, rand_len());
  endtask

  // Wait until every predicted result has come back; the block is idle then.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // Both registers in one burst; valid stays high across the two writes.
  task automatic write_regs(input logic [srrw_pkg::WIN_W-1:0] win,
                            input logic [IDX_W-1:0] total);
    logic [IDX_W-1:0] wdata;
    // unused upper bits of the window write carry noise half the time
    wdata = {($urandom_range(0, 1) ? (IDX_W-srrw_pkg::WIN_W)'($urandom) :
                                     (IDX_W-srrw_pkg::WIN_W)'(0)), win};
    cfg_valid_i <= 1'b1;
    cfg_index_i <= srrw_pkg::REG_WINDOW_SIZE;
    cfg_wdata_i <= wdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(srrw_pkg::REG_WINDOW_SIZE, wdata);
    cfg_index_i <= srrw_pkg::REG_TOTAL_FRAMES;
    cfg_wdata_i <= total;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(srrw_pkg::REG_TOTAL_FRAMES, total);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic around the delivery point: next frame in
  // line, frames further up the window, retransmits of delivered ones;
  // the rest is corruption and random sequence numbers.
  task automatic run_phase(input int unsigned count);
    int unsigned n, lo, hi, dp, pick, reach;
    repeat (count) begin
      dp = sb.deliver_pt;
      n  = sb.span();
      lo = (dp > n) ? dp - n : 0;
      hi = dp + n;
      if (hi > sb.total_reg) hi = sb.total_reg;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_frame(1'b0, srrw_pkg::SEQ_W'($urandom), $urandom, rand_len());
      end else if (pick < 14) begin
        send_frame(1'b1, srrw_pkg::SEQ_W'($urandom), $urandom, rand_len());
      end else if (pick < 24 && dp > lo) begin
        send_index($urandom_range(lo, dp - 1));
      end else if (hi > dp) begin
        reach = (hi - dp - 1 < 3) ? hi - dp - 1 : 3;
        if (pick < 60) send_index(dp + $urandom_range(0, reach));
        else send_index($urandom_range(dp, hi - 1));
      end else begin
        send_frame(1'b1, srrw_pkg::SEQ_W'($urandom), $urandom, rand_len());
      end
    end
  endtask

  // Full window out of order, then the head frame: 32 deliveries from one
  // item, sent while the receiver holds off and the sender keeps offering.
  task automatic burst_phase();
    int unsigned dp, tmp, j;
    int unsigned order[WIN_MAX-1];
    drain();
    dp = sb.deliver_pt;
    write_regs(srrw_pkg::WIN_W'($urandom_range(WIN_MAX, 63)),
               IDX_W'(dp + WIN_MAX + $urandom_range(0, 8)));
    foreach (order[i]) order[i] = dp + 1 + i;
    foreach (order[i]) begin
      j        = $urandom_range(0, WIN_MAX - 2);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    hold_req = 1'b1;
    foreach (order[i]) send_index(order[i]);
    send_index(dp);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned phase_no, n, lo, dp;
    logic [srrw_pkg::WIN_W-1:0] win;
    logic [IDX_W-1:0] total;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset config: window 1, nothing expected.
    send_frame(1'b0, 8'h00, 32'h0, 10'd0);             // corrupted
    send_frame(1'b1, 8'h00, 32'h1234, 10'd64);         // empty range -> ignored
    drain();
    write_regs(6'd4, 24'd10);
    send_frame(1'b1, 8'd1, 32'hA000_0001, 10'd100);    // buffered ahead of the gap
    send_frame(1'b1, 8'd1, 32'hBAD0_0001, 10'd7);      // duplicate within window
    send_frame(1'b1, 8'd0, 32'hA000_0000, 10'd512);    // fills the gap, delivers 0 and 1
    send_frame(1'b1, 8'd0, 32'h5555_5555, 10'd3);      // already delivered
    send_frame(1'b1, 8'd200, 32'h0, 10'd0);            // outside the window
    send_frame(1'b1, 8'd3, 32'hFFFF_FFFF, 10'h3FF);    // oversized length, all ones
    send_frame(1'b1, 8'd2, 32'h0, 10'd0);              // delivers 2 and 3
    send_frame(1'b0, 8'hFF, 32'hFFFF_FFFF, 10'h3FF);   // corrupted, all ones
    send_frame(1'b1, 8'd6, 32'hC000_0006, 10'd6);
    send_frame(1'b1, 8'd5, 32'hC000_0005, 10'd5);
    drain();
    // total lowered below buffered frames: delivery stops at 5
    write_regs(6'd4, 24'd5);
    send_frame(1'b1, 8'd4, 32'hC000_0004, 10'd4);
    drain();
    // window 0 behaves as 1; raised total lets a duplicate restart delivery
    write_regs(6'd0, 24'd20);
    send_frame(1'b1, 8'd5, 32'hDEAD_0005, 10'd9);      // duplicate, delivers 5 and 6
    send_frame(1'b1, 8'd4, 32'h0, 10'd1);              // wraps outside the window
    drain();

    // Random phases: a new window/total setting each time, idle between.
    phase_no = 0;
    while (frames_sent < ITEM_TARGET - CLOSE_ITEMS - 10) begin
      if (phase_no == 2) begin
        burst_phase();
      end else begin
        drain();
        case ($urandom_range(0, 5))
          0:       win = 6'd0;
          1:       win = 6'd1;
          2:       win = srrw_pkg::WIN_W'(WIN_MAX);
          3:       win = 6'd63;
          4:       win = srrw_pkg::WIN_W'($urandom_range(WIN_MAX + 1, 62));
          default: win = srrw_pkg::WIN_W'($urandom_range(2, WIN_MAX - 1));
        endcase
        dp = sb.deliver_pt;
        n  = (win < 1) ? 1 : ((win > WIN_MAX) ? WIN_MAX : win);
        lo = (dp > n) ? dp - n : 0;
        case ($urandom_range(0, 9))
          0, 1:    total = '1;                                    // largest transfer
          2:       total = IDX_W'($urandom_range(0, lo));         // empty range
          3, 4:    total = IDX_W'(dp + $urandom_range(0, 3));     // cut below buffered
          default: total = IDX_W'(dp + $urandom_range(1, 60));
        endcase
        write_regs(win, total);
        // pacing varies per phase, including stretches with no idling
        tx_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        rx_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        run_phase($urandom_range(10, 25));
      end
      phase_no++;
    end

    // Closing stretch at full rate on both sides.
    tx_pct = 0;
    rx_pct = 0;
    drain();
    write_regs(srrw_pkg::WIN_W'(WIN_MAX), IDX_W'(sb.deliver_pt + 40));
    run_phase(CLOSE_ITEMS);

    drain();
    repeat (100) @(posedge clk_i);   // catch stray results after the last one
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
